FILE: rtl/mrfbs_pkg.sv
// Shared types and constants for the best-sample selector.
package mrfbs_pkg;

    localparam int MaxNodes   = 64;
    localparam int MaxEdges   = 128;
    localparam int MaxStates  = 8;
    localparam int ScoreBits  = 16;
    localparam int NodeW      = $clog2(MaxNodes);
    localparam int EdgeW      = $clog2(MaxEdges);
    localparam int StateW     = $clog2(MaxStates);
    localparam int AccW       = 24;
    localparam int NodeAddrW  = NodeW + StateW;
    localparam int EdgeAddrW  = EdgeW + 2 * StateW;

    localparam logic signed [AccW-1:0] SatMin = {1'b1, {(AccW-1){1'b0}}};
    localparam logic signed [AccW-1:0] SatMax = {1'b0, {(AccW-1){1'b1}}};
    localparam logic signed [ScoreBits-1:0] ZeroCode = {1'b1, {(ScoreBits-1){1'b0}}};

    typedef enum logic [2:0] {
        ACT_NODE_POT  = 3'd0,
        ACT_EDGE_POT  = 3'd1,
        ACT_EDGE_ENDS = 3'd2,
        ACT_LABEL     = 3'd3,
        ACT_FINISH    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        CFG_NUM_NODES  = 2'd0,
        CFG_NUM_EDGES  = 2'd1,
        CFG_NUM_STATES = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NODE_ADD,
        ST_EDGE_RD,
        ST_EDGE_LAB,
        ST_EDGE_TBL,
        ST_EDGE_ADD,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // Saturating add of one log term; the zero code pins the sum at the minimum.
    function automatic logic signed [AccW-1:0] add_term(
        input logic signed [AccW-1:0] acc,
        input logic signed [ScoreBits-1:0] term
    );
        logic signed [AccW:0] s;
        begin
            s = {acc[AccW-1], acc} + {{(AccW+1-ScoreBits){term[ScoreBits-1]}}, term};
            if (term == ZeroCode || acc == SatMin)
                add_term = SatMin;
            else if (s < $signed({SatMin[AccW-1], SatMin}))
                add_term = SatMin;
            else if (s > $signed({SatMax[AccW-1], SatMax}))
                add_term = SatMax;
            else
                add_term = s[AccW-1:0];
        end
    endfunction

endpackage

FILE: rtl/mrf_best_sample_selector.sv
// Top level of the best-sample selector: control, scoring and result stage.
// Loads (actions 0..2) take effect when accepted and a non-final label reads the
// node table, then accumulates. The final label of a sample additionally walks
// every edge in use (endpoint read, label read, table read, accumulate), then
// compares and, on a new best, sweeps a copy over every label slot. Finish then
// emits one result beat per node in use, one per cycle while the output is taken.
// Write configuration only while no item is in flight. Tables need no clearing
// after reset.
module mrf_best_sample_selector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [5:0]  node_sel,
    input  logic [6:0]  edge_sel,
    input  logic [3:0]  state_a,
    input  logic [3:0]  state_b,
    input  logic [5:0]  end_a,
    input  logic [5:0]  end_b,
    input  logic signed [15:0] log_value,
    input  logic [3:0]  sample_label,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  node_index,
    output logic [3:0]  node_label,
    output logic signed [23:0] best_score,
    output logic        found,
    output logic        last
);

    localparam int NW = mrfbs_pkg::NodeW;
    localparam int EW = mrfbs_pkg::EdgeW;
    localparam int SW = mrfbs_pkg::StateW;
    localparam int AW = mrfbs_pkg::AccW;

    // Config registers
    logic [6:0] num_nodes_reg;
    logic [7:0] num_edges_reg;
    logic [3:0] num_states_reg;

    // Control and score state
    mrfbs_pkg::state_t state_reg, state_next;
    logic signed [AW-1:0] run_reg, run_next;
    logic signed [AW-1:0] best_reg, best_next;
    logic have_best_reg, have_best_next;
    logic bad_reg, bad_next;
    logic [NW-1:0] pos_reg, pos_next;
    logic [EW:0]   cnt_reg, cnt_next;   // edge walk, copy sweep or emit count
    logic          copy_reg, copy_next;
    logic          last_lab_reg, last_lab_next;
    logic          valid_ends_reg, valid_ends_next;

    // Output register
    logic          ov_reg, ov_next;
    logic [NW-1:0] oi_reg;
    logic          ol_reg;

    logic [6:0] nodes_used;
    logic [7:0] edges_used;
    logic [3:0] states_used;
    logic       in_fire;
    logic       lab_ok;
    logic [NW-1:0] lab_pos;
    logic       take_best;

    // Memory ports
    logic node_we, edge_we, ends_we, cur_we, best_we;
    logic [mrfbs_pkg::NodeAddrW-1:0] node_waddr, node_raddr;
    logic [mrfbs_pkg::EdgeAddrW-1:0] edge_waddr, edge_raddr;
    logic [EW-1:0] ends_addr;
    logic signed [15:0] node_rdata, edge_rdata;
    logic [NW-1:0] ea_out, eb_out;
    logic [NW-1:0] cur_waddr, cur_ra, cur_rb, best_waddr, best_raddr;
    logic [SW-1:0] cur_wdata, cur_da, cur_db, best_rdata;

    assign nodes_used  = (num_nodes_reg == 7'd0) ? 7'd1 :
                         (num_nodes_reg > 7'(mrfbs_pkg::MaxNodes)) ?
                         7'(mrfbs_pkg::MaxNodes) : num_nodes_reg;
    assign edges_used  = (num_edges_reg > 8'(mrfbs_pkg::MaxEdges)) ?
                         8'(mrfbs_pkg::MaxEdges) : num_edges_reg;
    assign states_used = (num_states_reg > 4'(mrfbs_pkg::MaxStates)) ?
                         4'(mrfbs_pkg::MaxStates) : num_states_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == mrfbs_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign lab_ok    = (sample_label >= 4'd1) && (sample_label <= states_used);
    assign lab_pos   = (7'(pos_reg) >= nodes_used) ? NW'(nodes_used - 7'd1) : pos_reg;
    assign take_best = !bad_reg && (!have_best_reg || run_reg > best_reg);

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_nodes_reg  <= 7'd1;
            num_edges_reg  <= 8'd0;
            num_states_reg <= 4'd8;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mrfbs_pkg::CFG_NUM_NODES:  num_nodes_reg  <= cfg_data[6:0];
                mrfbs_pkg::CFG_NUM_EDGES:  num_edges_reg  <= cfg_data;
                mrfbs_pkg::CFG_NUM_STATES: num_states_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Load writes and label writes
    always_comb
    begin
        node_we    = in_fire && action == mrfbs_pkg::ACT_NODE_POT &&
                     state_a >= 4'd1 && state_a <= 4'(mrfbs_pkg::MaxStates);
        edge_we    = in_fire && action == mrfbs_pkg::ACT_EDGE_POT &&
                     state_a >= 4'd1 && state_a <= 4'(mrfbs_pkg::MaxStates) &&
                     state_b >= 4'd1 && state_b <= 4'(mrfbs_pkg::MaxStates);
        ends_we    = in_fire && action == mrfbs_pkg::ACT_EDGE_ENDS;
        node_waddr = {node_sel, SW'(state_a - 4'd1)};
        edge_waddr = {edge_sel, SW'(state_b - 4'd1), SW'(state_a - 4'd1)};
        node_raddr = {lab_pos, SW'(sample_label - 4'd1)};
        edge_raddr = {cnt_reg[EW-1:0], cur_db, cur_da};
        ends_addr  = (state_reg == mrfbs_pkg::ST_IDLE) ? edge_sel : cnt_reg[EW-1:0];
        cur_we     = in_fire && action == mrfbs_pkg::ACT_LABEL;
        cur_waddr  = lab_pos;
        cur_wdata  = lab_ok ? SW'(sample_label - 4'd1) : '0;
        cur_ra     = ea_out;
        cur_rb     = eb_out;
    end

    // Copy sweep reads current labels on port a; the write lands in the following cycle
    assign best_we    = (state_reg == mrfbs_pkg::ST_DECIDE) && copy_reg && cnt_reg != '0;
    assign best_waddr = NW'(cnt_reg - 1'b1);
    // Reread the presented entry while the output is stalled
    assign best_raddr = (state_reg == mrfbs_pkg::ST_EMIT && (!ov_reg || out_ready)) ?
                        NW'(cnt_reg) : oi_reg;

    mrfbs_tables u_tables (
        .clk        (clk),
        .node_we    (node_we),
        .node_waddr (node_waddr),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .edge_we    (edge_we),
        .edge_waddr (edge_waddr),
        .edge_raddr (edge_raddr),
        .edge_rdata (edge_rdata),
        .wdata      (log_value),
        .ends_we    (ends_we),
        .ends_addr  (ends_addr),
        .end_a_in   (end_a),
        .end_b_in   (end_b),
        .end_a_out  (ea_out),
        .end_b_out  (eb_out)
    );

    logic [NW-1:0] copy_ra;
    assign copy_ra = (state_reg == mrfbs_pkg::ST_DECIDE) ? NW'(cnt_reg) : cur_ra;

    mrfbs_labels u_labels (
        .clk         (clk),
        .cur_we      (cur_we),
        .cur_waddr   (cur_waddr),
        .cur_wdata   (cur_wdata),
        .cur_raddr_a (copy_ra),
        .cur_raddr_b (cur_rb),
        .cur_rdata_a (cur_da),
        .cur_rdata_b (cur_db),
        .best_we     (best_we),
        .best_waddr  (best_waddr),
        .best_wdata  (cur_da),
        .best_raddr  (best_raddr),
        .best_rdata  (best_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrfbs_pkg::ST_IDLE:
            begin
                if (in_fire && action == mrfbs_pkg::ACT_LABEL)
                    state_next = mrfbs_pkg::ST_NODE_ADD;
                else if (in_fire && action == mrfbs_pkg::ACT_FINISH)
                    state_next = mrfbs_pkg::ST_EMIT;
            end
            mrfbs_pkg::ST_NODE_ADD:
            begin
                if (!last_lab_reg)
                    state_next = mrfbs_pkg::ST_IDLE;
                else if (edges_used == 8'd0)
                    state_next = mrfbs_pkg::ST_DECIDE;
                else
                    state_next = mrfbs_pkg::ST_EDGE_RD;
            end
            mrfbs_pkg::ST_EDGE_RD:
                state_next = mrfbs_pkg::ST_EDGE_LAB;
            mrfbs_pkg::ST_EDGE_LAB:
                state_next = mrfbs_pkg::ST_EDGE_TBL;
            mrfbs_pkg::ST_EDGE_TBL:
                state_next = mrfbs_pkg::ST_EDGE_ADD;
            mrfbs_pkg::ST_EDGE_ADD:
            begin
                if (8'(cnt_reg) + 8'd1 >= edges_used)
                    state_next = mrfbs_pkg::ST_DECIDE;
                else
                    state_next = mrfbs_pkg::ST_EDGE_RD;
            end
            mrfbs_pkg::ST_DECIDE:
            begin
                if (!copy_reg)
                begin
                    if (!take_best)
                        state_next = mrfbs_pkg::ST_IDLE;
                end
                else if (7'(cnt_reg) == 7'(mrfbs_pkg::MaxNodes))
                    state_next = mrfbs_pkg::ST_IDLE;
            end
            mrfbs_pkg::ST_EMIT:
            begin
                if (ov_reg && out_ready && ol_reg)
                    state_next = mrfbs_pkg::ST_IDLE;
            end
            default: state_next = mrfbs_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates
    always_comb
    begin
        run_next        = run_reg;
        best_next       = best_reg;
        have_best_next  = have_best_reg;
        bad_next        = bad_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        copy_next       = copy_reg;
        last_lab_next   = last_lab_reg;
        valid_ends_next = valid_ends_reg;
        ov_next         = ov_reg;
        unique case (state_reg)
            mrfbs_pkg::ST_IDLE:
            begin
                if (in_fire && action == mrfbs_pkg::ACT_LABEL)
                begin
                    copy_next     = lab_ok;  // reuse as "add node term"
                    if (!lab_ok) bad_next = 1'b1;
                    last_lab_next = (7'(lab_pos) + 7'd1 >= nodes_used);
                    pos_next      = NW'(lab_pos + 1'b1);
                end
                else if (in_fire && action == mrfbs_pkg::ACT_FINISH)
                begin
                    cnt_next = '0;
                    ov_next  = 1'b0;
                end
            end
            mrfbs_pkg::ST_NODE_ADD:
            begin
                if (copy_reg)
                    run_next = mrfbs_pkg::add_term(run_reg, node_rdata);
                cnt_next  = '0;
                copy_next = 1'b0;
            end
            mrfbs_pkg::ST_EDGE_LAB:
                valid_ends_next = (7'(ea_out) < nodes_used) && (7'(eb_out) < nodes_used);
            mrfbs_pkg::ST_EDGE_ADD:
            begin
                if (valid_ends_reg)
                    run_next = mrfbs_pkg::add_term(run_reg, edge_rdata);
                cnt_next = cnt_reg + 1'b1;
                if (8'(cnt_reg) + 8'd1 >= edges_used)
                    cnt_next = '0;
            end
            mrfbs_pkg::ST_DECIDE:
            begin
                if (!copy_reg)
                begin
                    if (take_best)
                    begin
                        have_best_next = 1'b1;
                        best_next      = run_reg;
                        copy_next      = 1'b1;
                        cnt_next       = '0;
                    end
                    else
                    begin
                        run_next = '0;
                        pos_next = '0;
                        bad_next = 1'b0;
                    end
                end
                else if (7'(cnt_reg) == 7'(mrfbs_pkg::MaxNodes))
                begin
                    copy_next = 1'b0;
                    run_next  = '0;
                    pos_next  = '0;
                    bad_next  = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            mrfbs_pkg::ST_EMIT:
            begin
                // Read best label at cnt, present it next cycle
                if (!ov_reg || out_ready)
                begin
                    if (ov_reg && ol_reg)
                    begin
                        ov_next        = 1'b0;
                        have_best_next = 1'b0;
                        best_next      = '0;
                        run_next       = '0;
                        pos_next       = '0;
                        bad_next       = 1'b0;
                    end
                    else
                    begin
                        ov_next  = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Emit stage index registers the read address, so it lines up with the read data
    always_ff @(posedge clk)
    begin
        if (state_reg == mrfbs_pkg::ST_EMIT && (!ov_reg || out_ready))
        begin
            oi_reg <= NW'(cnt_reg);
            ol_reg <= (7'(cnt_reg) + 7'd1 == nodes_used);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mrfbs_pkg::ST_IDLE;
            run_reg        <= '0;
            best_reg       <= '0;
            have_best_reg  <= 1'b0;
            bad_reg        <= 1'b0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            copy_reg       <= 1'b0;
            last_lab_reg   <= 1'b0;
            valid_ends_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_reg        <= run_next;
            best_reg       <= best_next;
            have_best_reg  <= have_best_next;
            bad_reg        <= bad_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            copy_reg       <= copy_next;
            last_lab_reg   <= last_lab_next;
            valid_ends_reg <= valid_ends_next;
            ov_reg         <= ov_next;
        end
    end

    // Drive result ports
    assign out_valid  = ov_reg;
    assign node_index = oi_reg;
    assign node_label = have_best_reg ? 4'(best_rdata) + 4'd1 : 4'd0;
    assign best_score = have_best_reg ? best_reg : '0;
    assign found      = have_best_reg;
    assign last       = ol_reg;

    // Results appear only during the emit sweep
    a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == mrfbs_pkg::ST_EMIT)
        else $error("result beat outside emit");

    // No new item during the edge walk of a sample
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrfbs_pkg::ST_EDGE_RD || state_reg == mrfbs_pkg::ST_EDGE_LAB ||
         state_reg == mrfbs_pkg::ST_EDGE_TBL || state_reg == mrfbs_pkg::ST_EDGE_ADD)
        |-> !in_ready)
        else $error("input taken during edge walk");

    // Best score only moves when a sample completes or a run ends
    a_best_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrfbs_pkg::ST_IDLE) |=> $stable(best_reg))
        else $error("best score changed while idle");

endmodule

FILE: rtl/mrfbs_tables.sv
// Potential tables and edge endpoint memories, each with a registered read.
module mrfbs_tables (
    input  logic                                    clk,
    input  logic                                    node_we,
    input  logic [mrfbs_pkg::NodeAddrW-1:0]         node_waddr,
    input  logic [mrfbs_pkg::NodeAddrW-1:0]         node_raddr,
    output logic signed [mrfbs_pkg::ScoreBits-1:0]  node_rdata,
    input  logic                                    edge_we,
    input  logic [mrfbs_pkg::EdgeAddrW-1:0]         edge_waddr,
    input  logic [mrfbs_pkg::EdgeAddrW-1:0]         edge_raddr,
    output logic signed [mrfbs_pkg::ScoreBits-1:0]  edge_rdata,
    input  logic signed [mrfbs_pkg::ScoreBits-1:0]  wdata,
    input  logic                                    ends_we,
    input  logic [mrfbs_pkg::EdgeW-1:0]             ends_addr,
    input  logic [mrfbs_pkg::NodeW-1:0]             end_a_in,
    input  logic [mrfbs_pkg::NodeW-1:0]             end_b_in,
    output logic [mrfbs_pkg::NodeW-1:0]             end_a_out,
    output logic [mrfbs_pkg::NodeW-1:0]             end_b_out
);

    logic [mrfbs_pkg::ScoreBits-1:0] node_mem [mrfbs_pkg::MaxNodes*mrfbs_pkg::MaxStates];
    logic [mrfbs_pkg::ScoreBits-1:0] edge_mem
        [mrfbs_pkg::MaxEdges*mrfbs_pkg::MaxStates*mrfbs_pkg::MaxStates];
    logic [2*mrfbs_pkg::NodeW-1:0]   ends_mem [mrfbs_pkg::MaxEdges];

    // Node potentials
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= wdata;
        end
        node_rdata <= node_mem[node_raddr];
    end

    // Edge potentials
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= wdata;
        end
        edge_rdata <= edge_mem[edge_raddr];
    end

    // Endpoints share one address: loads and the edge walk never overlap
    always_ff @(posedge clk)
    begin
        if (ends_we)
        begin
            ends_mem[ends_addr] <= {end_a_in, end_b_in};
        end
        {end_a_out, end_b_out} <= ends_mem[ends_addr];
    end

endmodule

FILE: rtl/mrfbs_labels.sv
// Current and best label stores with a sweep copy on a new best sample.
module mrfbs_labels (
    input  logic                               clk,
    input  logic                               cur_we,
    input  logic [mrfbs_pkg::NodeW-1:0]        cur_waddr,
    input  logic [mrfbs_pkg::StateW-1:0]       cur_wdata,
    input  logic [mrfbs_pkg::NodeW-1:0]        cur_raddr_a,
    input  logic [mrfbs_pkg::NodeW-1:0]        cur_raddr_b,
    output logic [mrfbs_pkg::StateW-1:0]       cur_rdata_a,
    output logic [mrfbs_pkg::StateW-1:0]       cur_rdata_b,
    input  logic                               best_we,
    input  logic [mrfbs_pkg::NodeW-1:0]        best_waddr,
    input  logic [mrfbs_pkg::StateW-1:0]       best_wdata,
    input  logic [mrfbs_pkg::NodeW-1:0]        best_raddr,
    output logic [mrfbs_pkg::StateW-1:0]       best_rdata
);

    logic [mrfbs_pkg::StateW-1:0] cur_mem  [mrfbs_pkg::MaxNodes];
    logic [mrfbs_pkg::StateW-1:0] best_mem [mrfbs_pkg::MaxNodes];

    // Current sample: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        cur_rdata_a <= cur_mem[cur_raddr_a];
        cur_rdata_b <= cur_mem[cur_raddr_b];
    end

    // Best sample
    always_ff @(posedge clk)
    begin
        if (best_we)
        begin
            best_mem[best_waddr] <= best_wdata;
        end
        best_rdata <= best_mem[best_raddr];
    end

endmodule

FILE: bench/tb_mrf_best_sample_selector.sv
// Self-checking testbench for the best-sample selector: loads, samples, finish readout.
module tb_mrf_best_sample_selector;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]         act;
        logic [5:0]         node;
        logic [6:0]         edg;
        logic [3:0]         sa;
        logic [3:0]         sb;
        logic [5:0]         ea;
        logic [5:0]         eb;
        logic signed [15:0] lv;
        logic [3:0]         lab;
    } op_beat_t;

    typedef struct {
        logic [5:0]         idx;
        logic [3:0]         lab;
        logic signed [23:0] score;
        logic               fnd;
        logic               lst;
    } label_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] action = '0;
    logic [5:0] node_sel = '0;
    logic [6:0] edge_sel = '0;
    logic [3:0] state_a = '0;
    logic [3:0] state_b = '0;
    logic [5:0] end_a = '0;
    logic [5:0] end_b = '0;
    logic signed [15:0] log_value = '0;
    logic [3:0] sample_label = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [5:0] node_index;
    logic [3:0] node_label;
    logic signed [23:0] best_score;
    logic found;
    logic last;

    mrf_best_sample_selector dut (.*);

    // Shadow copy of the block's tables, registers and search state
    logic signed [15:0] node_pot [64][8];
    logic signed [15:0] edge_pot [128][8][8];
    logic [5:0] end_first [128];
    logic [5:0] end_second [128];
    logic [2:0] cur_lab [64];
    logic [2:0] best_lab [64];
    logic signed [23:0] run_score = '0;
    logic signed [23:0] top_score = '0;
    logic have_top = 1'b0;
    int pos = 0;
    logic bad = 1'b0;
    int reg_nodes = 1;
    int reg_edges = 0;
    int reg_states = 8;

    label_beat_t label_q[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int stall_cnt = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int nodes_in_use();
        return (reg_nodes == 0) ? 1 : ((reg_nodes > 64) ? 64 : reg_nodes);
    endfunction

    function automatic int edges_in_use();
        return (reg_edges > 128) ? 128 : reg_edges;
    endfunction

    function automatic int states_in_use();
        return (reg_states > 8) ? 8 : reg_states;
    endfunction

    // Saturating log-potential accumulate; the zero code pins the sum at the floor
    function automatic logic signed [23:0] sum_log(logic signed [23:0] acc,
                                                   logic signed [15:0] term);
        int s;
        if (term == mrfbs_pkg::ZeroCode || acc == mrfbs_pkg::SatMin)
            return mrfbs_pkg::SatMin;
        s = int'(acc) + int'(term);
        if (s < int'(mrfbs_pkg::SatMin))
            return mrfbs_pkg::SatMin;
        if (s > int'(mrfbs_pkg::SatMax))
            return mrfbs_pkg::SatMax;
        return s[23:0];
    endfunction

    // Advance the shadow state by one accepted beat and queue its results
    task automatic score_beat(op_beat_t b);
        int nodes;
        int la;
        int lb;
        label_beat_t r;
        nodes = nodes_in_use();
        case (b.act)
            mrfbs_pkg::ACT_NODE_POT:
            begin
                if (b.sa >= 1 && b.sa <= 8)
                    node_pot[b.node][b.sa - 1] = b.lv;
            end
            mrfbs_pkg::ACT_EDGE_POT:
            begin
                if (b.sa >= 1 && b.sa <= 8 && b.sb >= 1 && b.sb <= 8)
                    edge_pot[b.edg][b.sb - 1][b.sa - 1] = b.lv;
            end
            mrfbs_pkg::ACT_EDGE_ENDS:
            begin
                end_first[b.edg] = b.ea;
                end_second[b.edg] = b.eb;
            end
            mrfbs_pkg::ACT_LABEL:
            begin
                if (pos >= nodes)
                    pos = nodes - 1;
                if (b.lab >= 1 && b.lab <= states_in_use())
                begin
                    cur_lab[pos] = 3'(b.lab - 4'd1);
                    run_score = sum_log(run_score, node_pot[pos][b.lab - 1]);
                end
                else
                begin
                    cur_lab[pos] = '0;
                    bad = 1'b1;
                end
                pos++;
                if (pos >= nodes)
                begin
                    // walk the edges whose ends both lie in use
                    for (int e = 0; e < edges_in_use(); e++)
                    begin
                        if (end_first[e] < nodes && end_second[e] < nodes)
                        begin
                            la = cur_lab[end_first[e]];
                            lb = cur_lab[end_second[e]];
                            run_score = sum_log(run_score, edge_pot[e][lb][la]);
                        end
                    end
                    if (!bad && (!have_top || run_score > top_score))
                    begin
                        have_top = 1'b1;
                        top_score = run_score;
                        best_lab = cur_lab;
                    end
                    run_score = '0;
                    pos = 0;
                    bad = 1'b0;
                end
            end
            mrfbs_pkg::ACT_FINISH:
            begin
                for (int i = 0; i < nodes; i++)
                begin
                    r.idx = 6'(i);
                    r.lab = have_top ? best_lab[i] + 4'd1 : 4'd0;
                    r.score = have_top ? top_score : '0;
                    r.fnd = have_top;
                    r.lst = (i + 1 == nodes);
                    label_q.push_back(r);
                end
                have_top = 1'b0;
                top_score = '0;
                run_score = '0;
                pos = 0;
                bad = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Present one beat, hold it until taken, then score it
    task automatic send_beat(op_beat_t b);
        int gap;
        gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= b.act;
        node_sel <= b.node;
        edge_sel <= b.edg;
        state_a <= b.sa;
        state_b <= b.sb;
        end_a <= b.ea;
        end_b <= b.eb;
        log_value <= b.lv;
        sample_label <= b.lab;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        score_beat(b);
    endtask

    // Unused fields carry random bits so every input bit toggles
    task automatic send_op(logic [2:0] act, int node, int edg, int sa, int sb,
                           int ea, int eb, int lv, int lab);
        op_beat_t b;
        b.act = act;
        b.node = (node < 0) ? 6'($urandom) : 6'(node);
        b.edg = (edg < 0) ? 7'($urandom) : 7'(edg);
        b.sa = (sa < 0) ? 4'($urandom) : 4'(sa);
        b.sb = (sb < 0) ? 4'($urandom) : 4'(sb);
        b.ea = (ea < 0) ? 6'($urandom) : 6'(ea);
        b.eb = (eb < 0) ? 6'($urandom) : 6'(eb);
        b.lv = 16'(lv);
        b.lab = (lab < 0) ? 4'($urandom) : 4'(lab);
        send_beat(b);
    endtask

    task automatic send_label(int lab);
        send_op(mrfbs_pkg::ACT_LABEL, -1, -1, -1, -1, -1, -1, $urandom, lab);
    endtask

    task automatic send_finish();
        send_op(mrfbs_pkg::ACT_FINISH, -1, -1, -1, -1, -1, -1, $urandom, -1);
    endtask

    function automatic int pick_log();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return -32768;
        if (r < 10)
            return 32767;
        if (r < 16)
            return -32767;
        if (r < 30)
            return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(2000)) - 1000;
    endfunction

    // Drop valid and wait for every queued result, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (label_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(mrfbs_pkg::cfg_index_t idx, int v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 8'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            mrfbs_pkg::CFG_NUM_NODES: reg_nodes = v & 'h7f;
            mrfbs_pkg::CFG_NUM_EDGES: reg_edges = v & 'hff;
            mrfbs_pkg::CFG_NUM_STATES: reg_states = v & 'hf;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(int n, int e, int s);
        drain();
        write_reg(mrfbs_pkg::CFG_NUM_NODES, n);
        write_reg(mrfbs_pkg::CFG_NUM_EDGES, e);
        write_reg(mrfbs_pkg::CFG_NUM_STATES, s);
    endtask

    // Load every table entry that samples under the current registers can read
    task automatic load_tables(int in_range_pct);
        int nodes;
        int span;
        int a;
        int b;
        nodes = nodes_in_use();
        span = (states_in_use() < 1) ? 1 : states_in_use();
        for (int n = 0; n < nodes; n++)
            for (int s = 1; s <= states_in_use(); s++)
                send_op(mrfbs_pkg::ACT_NODE_POT, n, -1, s, -1, -1, -1, pick_log(), -1);
        for (int e = 0; e < edges_in_use(); e++)
        begin
            if (nodes == 64 || $urandom_range(99) < in_range_pct)
            begin
                a = $urandom_range(nodes - 1);
                b = $urandom_range(nodes - 1);
            end
            else
            begin
                a = $urandom_range(63, nodes);
                b = $urandom_range(63, 0);
            end
            send_op(mrfbs_pkg::ACT_EDGE_ENDS, -1, e, -1, -1, a, b, $urandom, -1);
            if (a < nodes && b < nodes)
                for (int x = 1; x <= span; x++)
                    for (int y = 1; y <= span; y++)
                        send_op(mrfbs_pkg::ACT_EDGE_POT, -1, e, x, y, -1, -1,
                                pick_log(), -1);
        end
    endtask

    // Field extremes, every action, ties, bad labels, zero potential, partial sample
    task automatic test_directed();
        set_config(2, 0, 8);
        load_tables(100);
        send_finish();
        send_label(8);
        send_label(1);
        send_label(5);
        send_label(1);
        send_label(1);
        send_label(1);
        send_label(1);
        send_label(1);
        send_label(1);
        send_label(9);
        send_label(0);
        send_label(15);
        send_op(mrfbs_pkg::ACT_NODE_POT, 0, -1, 0, -1, -1, -1, 32767, -1);
        send_op(mrfbs_pkg::ACT_NODE_POT, 63, -1, 9, -1, -1, -1, 32767, -1);
        send_op(mrfbs_pkg::ACT_EDGE_POT, -1, 127, 0, 8, -1, -1, -32768, -1);
        send_op(mrfbs_pkg::ACT_EDGE_POT, -1, 0, 8, 15, -1, -1, -32768, -1);
        send_op(mrfbs_pkg::ACT_NODE_POT, 0, -1, 2, -1, -1, -1, -32768, -1);
        send_label(2);
        send_label(8);
        send_label(8);
        send_op(3'd5, -1, -1, -1, -1, -1, -1, $urandom, -1);
        send_op(3'd6, -1, -1, -1, -1, -1, -1, $urandom, -1);
        send_op(3'd7, -1, -1, -1, -1, -1, -1, $urandom, -1);
        send_label(3);
        send_finish();
        send_label(4);
        send_label(4);
        send_label(4);
        send_finish();
        drain();
    endtask

    // Register values at and beyond their limits
    task automatic test_register_extremes();
        set_config(127, 0, 1);
        load_tables(100);
        for (int i = 0; i < 64; i++)
            send_label(1);
        send_finish();
        set_config(0, 0, 0);
        send_label(1);
        send_label(0);
        send_finish();
        set_config(1, 0, 15);
        load_tables(100);
        send_label(8);
        send_label(7);
        send_finish();
        set_config(64, 255, 8);
        send_finish();
        drain();
    endtask

    // Random samples, mostly with valid labels, sprinkled with noise beats
    task automatic test_random(int count, int s_idle, int r_idle);
        int r;
        int lab;
        send_idle = s_idle;
        recv_idle = r_idle;
        set_config($urandom_range(1, 6), $urandom_range(0, 4), $urandom_range(1, 4));
        load_tables(60);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain();
            r = $urandom_range(99);
            if (r < 6)
                send_finish();
            else if (r < 14)
            begin
                case ($urandom_range(3))
                    0: send_op(3'($urandom_range(7, 5)), -1, -1, -1, -1, -1, -1,
                               $urandom, -1);
                    1: send_op(mrfbs_pkg::ACT_NODE_POT, -1, -1, -1, -1, -1, -1,
                               pick_log(), -1);
                    2: send_op(mrfbs_pkg::ACT_EDGE_POT, -1, -1, -1, -1, -1, -1,
                               pick_log(), -1);
                    default: send_op(mrfbs_pkg::ACT_EDGE_ENDS, -1,
                                     $urandom_range(127, edges_in_use()),
                                     -1, -1, -1, -1, $urandom, -1);
                endcase
            end
            else
            begin
                lab = ($urandom_range(99) < 85) ? $urandom_range(states_in_use(), 1)
                                                : $urandom_range(15);
                send_label(lab);
            end
        end
        send_finish();
        drain();
    endtask

    // Check each result beat against the oldest expectation; vary output stalls
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (label_q.size() == 0)
            begin
                $error("unexpected result beat node_index=%0d", node_index);
                errors++;
            end
            else
            begin
                automatic label_beat_t x = label_q.pop_front();
                if (node_index !== x.idx)
                begin
                    $error("node_index expected %0d got %0d", x.idx, node_index);
                    errors++;
                end
                if (node_label !== x.lab)
                begin
                    $error("node_label expected %0d got %0d", x.lab, node_label);
                    errors++;
                end
                if (best_score !== x.score)
                begin
                    $error("best_score expected %0d got %0d", x.score, best_score);
                    errors++;
                end
                if (found !== x.fnd)
                begin
                    $error("found expected %0d got %0d", x.fnd, found);
                    errors++;
                end
                if (last !== x.lst)
                begin
                    $error("last expected %0d got %0d", x.lst, last);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // End the run if no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > 20000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random(24, 15, 72);
        test_random(24, 72, 15);
        test_random(24, 0, 0);
        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
